FILE: hdl/ttdt_pkg.sv
// Shared types and codes for the two-tone discrimination trial sequencer.
// No dependencies; imported by every module under hdl/.
package ttdt_pkg;

  // Trial state codes
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SAMPLE1  = 4'd1;
  localparam logic [3:0] ST_SAMPLE2  = 4'd2;
  localparam logic [3:0] ST_DELAY    = 4'd3;
  localparam logic [3:0] ST_GOCUE    = 4'd4;
  localparam logic [3:0] ST_RESPONSE = 4'd5;
  localparam logic [3:0] ST_REWARD   = 4'd6;
  localparam logic [3:0] ST_PUNISH   = 4'd7;
  localparam logic [3:0] ST_ITI      = 4'd8;

  // Trial types
  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_1    = 2'd1;
  localparam logic [1:0] TYPE_2    = 2'd2;

  // Tone commands
  localparam logic [1:0] TONE_NONE    = 2'd0;
  localparam logic [1:0] TONE_SAMPLE1 = 2'd1;
  localparam logic [1:0] TONE_SAMPLE2 = 2'd2;
  localparam logic [1:0] TONE_GOCUE   = 2'd3;

  // Timer select codes
  localparam logic [2:0] TMR_NONE     = 3'd0;
  localparam logic [2:0] TMR_TRAIN    = 3'd1;
  localparam logic [2:0] TMR_DELAY    = 3'd2;
  localparam logic [2:0] TMR_CUE      = 3'd3;
  localparam logic [2:0] TMR_RESPONSE = 3'd4;
  localparam logic [2:0] TMR_CONSUME  = 3'd5;
  localparam logic [2:0] TMR_PUNISH   = 3'd6;
  localparam logic [2:0] TMR_ITI      = 3'd7;

  // Trial outcomes
  localparam logic [1:0] OUT_ABORT     = 2'd0;
  localparam logic [1:0] OUT_HIT       = 2'd1;
  localparam logic [1:0] OUT_INCORRECT = 2'd2;
  localparam logic [1:0] OUT_NORESP    = 2'd3;

  // Register indexes
  localparam logic REG_MAX_REPEAT  = 1'b0;
  localparam logic REG_EARLY_PUNISH = 1'b1;

  localparam logic [7:0] RUN_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] max_repeat;
    logic       early_lick_punish;
  } cfg_t;

  typedef struct packed {
    logic lick_spout1;
    logic lick_spout2;
    logic in_position;
    logic timer_expired;
    logic coin_bit;
  } inp_t;

  typedef struct packed {
    logic [3:0] trial_state;
    logic [1:0] trial_type;
    logic [1:0] previous_type;
    logic [7:0] run_length;
    logic [1:0] pending_outcome;
  } ctx_t;

  typedef struct packed {
    logic [3:0] state_now;
    logic       entered;
    logic [1:0] tone_command;
    logic [1:0] reward_spout;
    logic [2:0] timer_select;
    logic       trial_booked;
    logic [1:0] trial_outcome;
  } res_t;

endpackage

FILE: hdl/two_tone_discrimination_trial.sv
// Top level of the two-tone discrimination trial sequencer.
// Depends on ttdt_pkg, ttdt_regs and ttdt_step.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word per polling cycle holding
//    the two lick flags, the position level, the timer-expired flag and a
//    coin bit. A word is taken at a clock edge with in_valid high and
//    in_stall low.
//  - Output channel (out_valid / out_stall): exactly one result word per
//    input word: the state entered (or held), the entry flag, tone command,
//    reward spout, timer select and, on entry to the interval, the booked
//    trial and its outcome.
//  - Path: a word taken at a clock edge passes the input register, one pass
//    of next-state logic and the result register before its result shows.
//  - Throughput: one word per cycle while not stalled; the trial state is
//    updated as the word enters the result register; the next word sees it.
//  - Receiver stall: the result register holds; the input register still
//    takes one more word, then in_stall rises until the result is taken.
//  - Reset (rst, synchronous): trial state idle, type 1, no type history,
//    pending outcome abort, max_repeat 3, early_lick_punish 1, both channels
//    empty.
//  - Registers over APB: max_repeat at 0x0, early_lick_punish at 0x4; write
//    only while no word is in flight.
module two_tone_discrimination_trial import ttdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input word
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        lick_spout1,
  input  logic        lick_spout2,
  input  logic        in_position,
  input  logic        timer_expired,
  input  logic        coin_bit,
  // result word
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  state_now,
  output logic        entered,
  output logic [1:0]  tone_command,
  output logic [1:0]  reward_spout,
  output logic [2:0]  timer_select,
  output logic        trial_booked,
  output logic [1:0]  trial_outcome
);

  cfg_t cfg;
  inp_t in_word;
  logic in_full;
  ctx_t ctx;
  ctx_t ctx_next;
  res_t res_next;
  res_t res;
  logic advance;

  ttdt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register: refills in the same cycle the held word moves on
  assign advance  = in_full & (~out_valid | ~out_stall);
  assign in_stall = in_full & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word.lick_spout1   <= lick_spout1;
      in_word.lick_spout2   <= lick_spout2;
      in_word.in_position   <= in_position;
      in_word.timer_expired <= timer_expired;
      in_word.coin_bit      <= coin_bit;
    end
  end

  ttdt_step u_step (
    .ctx      (ctx),
    .cfg      (cfg),
    .inp      (in_word),
    .ctx_next (ctx_next),
    .res      (res_next)
  );

  // trial context commits as the word passes to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.trial_state     <= ST_IDLE;
      ctx.trial_type      <= TYPE_1;
      ctx.previous_type   <= TYPE_NONE;
      ctx.run_length      <= 8'd0;
      ctx.pending_outcome <= OUT_ABORT;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign state_now     = res.state_now;
  assign entered       = res.entered;
  assign tone_command  = res.tone_command;
  assign reward_spout  = res.reward_spout;
  assign timer_select  = res.timer_select;
  assign trial_booked  = res.trial_booked;
  assign trial_outcome = res.trial_outcome;

  // checks

  // a held state carries no actions
  a_hold_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !entered) |->
      (tone_command == TONE_NONE && reward_spout == 2'd0 &&
       timer_select == TMR_NONE && !trial_booked && trial_outcome == OUT_ABORT))
    else $error("actions emitted without a state entry");

  // booking happens only on entry to the interval
  a_book_iti: assert property (@(posedge clk) disable iff (rst)
    (out_valid && trial_booked) |-> (entered && state_now == ST_ITI))
    else $error("trial booked outside interval entry");

  // water only on entry to reward, at the spout matching the trial type
  a_reward: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reward_spout != 2'd0) |->
      (state_now == ST_REWARD && reward_spout == ctx.trial_type))
    else $error("reward outside reward entry");

  // the sequencer never lands on an unused state code
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    advance |=> (ctx.trial_state <= ST_ITI))
    else $error("trial state out of range");

endmodule

FILE: hdl/ttdt_regs.sv
// Configuration registers behind an APB-style slave port.
// Depends on ttdt_pkg (cfg_t, register indexes).
module ttdt_regs import ttdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_repeat        <= 8'd3;
      cfg.early_lick_punish <= 1'b1;
    end else if (wr_en) begin
      if (paddr[2] == REG_MAX_REPEAT) begin
        cfg.max_repeat <= pwdata[7:0];
      end else begin
        cfg.early_lick_punish <= pwdata[0];
      end
    end
  end

  // paddr[1:0] ignored: word aligned map
  always_comb begin
    if (paddr[2] == REG_EARLY_PUNISH) begin
      prdata = {31'd0, cfg.early_lick_punish};
    end else begin
      prdata = {24'd0, cfg.max_repeat};
    end
  end

endmodule

FILE: hdl/ttdt_step.sv
// Next-state and entry-action logic for one polling word.
// Depends on ttdt_pkg (codes, ctx_t, cfg_t, inp_t, res_t).
module ttdt_step import ttdt_pkg::*; (
  input  ctx_t ctx,
  input  cfg_t cfg,
  input  inp_t inp,
  output ctx_t ctx_next,
  output res_t res
);

  logic       licked;
  logic       early;
  logic       in_trial;
  logic [1:0] coin_type;
  logic [1:0] draw_type;
  logic [3:0] sample_st;
  logic       right;
  logic       wrong;
  logic       moved;
  logic [3:0] target;

  assign licked    = inp.lick_spout1 | inp.lick_spout2;
  assign early     = licked & cfg.early_lick_punish;
  assign in_trial  = (ctx.trial_state == ST_SAMPLE1) || (ctx.trial_state == ST_SAMPLE2) ||
                     (ctx.trial_state == ST_DELAY)   || (ctx.trial_state == ST_GOCUE);
  assign sample_st = (ctx.trial_type == TYPE_1) ? ST_SAMPLE1 : ST_SAMPLE2;
  assign right     = (ctx.trial_type == TYPE_1) ? inp.lick_spout1 : inp.lick_spout2;
  assign wrong     = (ctx.trial_type == TYPE_1) ? inp.lick_spout2 : inp.lick_spout1;

  // Coin draw with repeat cap
  always_comb begin
    coin_type = inp.coin_bit ? TYPE_2 : TYPE_1;
    draw_type = coin_type;
    if (coin_type == ctx.previous_type && ctx.run_length >= cfg.max_repeat) begin
      draw_type = (coin_type == TYPE_1) ? TYPE_2 : TYPE_1;
    end
  end

  always_comb begin
    ctx_next = ctx;
    moved    = 1'b0;
    target   = ctx.trial_state;
    res      = '0;
    res.state_now = ctx.trial_state;

    if (in_trial && !inp.in_position) begin
      // leaving the port aborts, ahead of any lick test
      ctx_next.pending_outcome = OUT_ABORT;
      moved  = 1'b1;
      target = ST_ITI;
    end else begin
      case (ctx.trial_state)
        ST_IDLE: begin
          if (inp.in_position) begin
            moved = 1'b1;
            ctx_next.trial_type = draw_type;
            if (draw_type == ctx.previous_type) begin
              if (ctx.run_length != RUN_MAX) begin
                ctx_next.run_length = ctx.run_length + 8'd1;
              end
            end else begin
              ctx_next.previous_type = draw_type;
              ctx_next.run_length    = 8'd1;
            end
            target = (draw_type == TYPE_1) ? ST_SAMPLE1 : ST_SAMPLE2;
          end
        end
        ST_SAMPLE1, ST_SAMPLE2: begin
          if (early) begin
            moved = 1'b1;
          end else if (inp.timer_expired) begin
            moved  = 1'b1;
            target = ST_DELAY;
          end
        end
        ST_DELAY: begin
          if (early) begin
            moved  = 1'b1;
            target = sample_st;
          end else if (inp.timer_expired) begin
            moved  = 1'b1;
            target = ST_GOCUE;
          end
        end
        ST_GOCUE: begin
          if (inp.timer_expired) begin
            moved  = 1'b1;
            target = ST_RESPONSE;
          end
        end
        ST_RESPONSE: begin
          if (right) begin
            ctx_next.pending_outcome = OUT_HIT;
            res.reward_spout = ctx.trial_type;
            moved  = 1'b1;
            target = ST_REWARD;
          end else if (wrong) begin
            ctx_next.pending_outcome = OUT_INCORRECT;
            moved  = 1'b1;
            target = ST_PUNISH;
          end else if (inp.timer_expired || !inp.in_position) begin
            ctx_next.pending_outcome = OUT_NORESP;
            moved  = 1'b1;
            target = ST_ITI;
          end
        end
        ST_REWARD, ST_PUNISH: begin
          if (inp.timer_expired) begin
            moved  = 1'b1;
            target = ST_ITI;
          end
        end
        ST_ITI: begin
          if (inp.timer_expired) begin
            moved  = 1'b1;
            target = ST_IDLE;
          end
        end
        default: begin
          // unused codes hold silently
        end
      endcase
    end

    if (moved) begin
      ctx_next.trial_state = target;
      res.state_now = target;
      res.entered   = 1'b1;
      case (target)
        ST_SAMPLE1: begin
          res.tone_command = TONE_SAMPLE1;
          res.timer_select = TMR_TRAIN;
        end
        ST_SAMPLE2: begin
          res.tone_command = TONE_SAMPLE2;
          res.timer_select = TMR_TRAIN;
        end
        ST_DELAY:    res.timer_select = TMR_DELAY;
        ST_GOCUE: begin
          res.tone_command = TONE_GOCUE;
          res.timer_select = TMR_CUE;
        end
        ST_RESPONSE: res.timer_select = TMR_RESPONSE;
        ST_REWARD:   res.timer_select = TMR_CONSUME;
        ST_PUNISH:   res.timer_select = TMR_PUNISH;
        ST_ITI: begin
          res.timer_select  = TMR_ITI;
          res.trial_booked  = 1'b1;
          res.trial_outcome = ctx_next.pending_outcome;
        end
        default: begin
          res.timer_select = TMR_NONE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_two_tone_discrimination_trial.sv
// Self-checking testbench for the two-tone discrimination trial sequencer.
// Depends on ttdt_pkg and two_tone_discrimination_trial (hdl/); nothing else.
// Predicts every result word in-line and checks it field by field.
`timescale 1ns / 1ps

module tb_two_tone_discrimination_trial import ttdt_pkg::*; ();

  // APB byte addresses, 4 bytes per register
  localparam logic [2:0] ADDR_MAX_REPEAT   = {REG_MAX_REPEAT, 2'b00};
  localparam logic [2:0] ADDR_EARLY_PUNISH = {REG_EARLY_PUNISH, 2'b00};

  // Hard stop: far beyond the slowest legal run (~2k words, heavy idling)
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;
  // Extra wait after the last result is taken, as pipeline padding
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        lick_spout1 = 1'b0;
  logic        lick_spout2 = 1'b0;
  logic        in_position = 1'b0;
  logic        timer_expired = 1'b0;
  logic        coin_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  state_now;
  logic        entered;
  logic [1:0]  tone_command;
  logic [1:0]  reward_spout;
  logic [2:0]  timer_select;
  logic        trial_booked;
  logic [1:0]  trial_outcome;

  two_tone_discrimination_trial u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .lick_spout1   (lick_spout1),
    .lick_spout2   (lick_spout2),
    .in_position   (in_position),
    .timer_expired (timer_expired),
    .coin_bit      (coin_bit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .state_now     (state_now),
    .entered       (entered),
    .tone_command  (tone_command),
    .reward_spout  (reward_spout),
    .timer_select  (timer_select),
    .trial_booked  (trial_booked),
    .trial_outcome (trial_outcome)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Sequencer mirror: state and registers as the block should hold them.
  // Updated only when a word is taken, so it always matches the block's
  // view at the moment the next word is shaped.
  // ---------------------------------------------------------------------
  logic [3:0] seq_state    = ST_IDLE;
  logic [1:0] trial_kind   = TYPE_1;
  logic [1:0] last_kind    = TYPE_NONE;
  logic [7:0] kind_run     = 8'd0;
  logic [1:0] held_outcome = OUT_ABORT;
  logic [7:0] cfg_max_repeat   = 8'd3;
  logic       cfg_early_punish = 1'b1;

  res_t expected_results[$];

  int gap_pct   = 0;   // sender idle chance per cycle, percent
  int stall_pct = 0;   // receiver stall chance per cycle, percent
  int hold_left = 0;   // cycles left in a forced receiver hold-off

  int n_errors  = 0;
  int n_words   = 0;
  int n_checked = 0;
  int n_booked[4] = '{0, 0, 0, 0};

  // Next state and entry actions for one polling word
  function automatic res_t predict_step(input inp_t w);
    res_t       r;
    logic [3:0] nxt;
    logic       moved;
    logic       licked;
    logic       right_lick;
    logic       wrong_lick;
    logic [1:0] pick;
    r          = '0;
    nxt        = seq_state;
    moved      = 1'b0;
    licked     = w.lick_spout1 | w.lick_spout2;
    right_lick = (trial_kind == TYPE_1) ? w.lick_spout1 : w.lick_spout2;
    wrong_lick = (trial_kind == TYPE_1) ? w.lick_spout2 : w.lick_spout1;

    // leaving the port aborts; checked ahead of any lick rule
    if ((seq_state == ST_SAMPLE1 || seq_state == ST_SAMPLE2 ||
         seq_state == ST_DELAY || seq_state == ST_GOCUE) && !w.in_position) begin
      held_outcome = OUT_ABORT;
      nxt = ST_ITI;
      moved = 1'b1;
    end else begin
      case (seq_state)
        ST_IDLE: begin
          if (w.in_position) begin
            pick = w.coin_bit ? TYPE_2 : TYPE_1;
            // repeat cap flips the coin
            if (pick == last_kind && kind_run >= cfg_max_repeat)
              pick = (pick == TYPE_1) ? TYPE_2 : TYPE_1;
            if (pick == last_kind) begin
              if (kind_run != RUN_MAX) kind_run = kind_run + 8'd1;
            end else begin
              last_kind = pick;
              kind_run = 8'd1;
            end
            trial_kind = pick;
            nxt = (pick == TYPE_1) ? ST_SAMPLE1 : ST_SAMPLE2;
            moved = 1'b1;
          end
        end
        ST_SAMPLE1, ST_SAMPLE2: begin
          if (licked && cfg_early_punish) begin
            moved = 1'b1;  // re-enter same sample
          end else if (w.timer_expired) begin
            nxt = ST_DELAY;
            moved = 1'b1;
          end
        end
        ST_DELAY: begin
          if (licked && cfg_early_punish) begin
            nxt = (trial_kind == TYPE_1) ? ST_SAMPLE1 : ST_SAMPLE2;
            moved = 1'b1;
          end else if (w.timer_expired) begin
            nxt = ST_GOCUE;
            moved = 1'b1;
          end
        end
        ST_GOCUE: begin
          if (w.timer_expired) begin
            nxt = ST_RESPONSE;
            moved = 1'b1;
          end
        end
        ST_RESPONSE: begin
          if (right_lick) begin
            r.reward_spout = trial_kind;
            held_outcome = OUT_HIT;
            nxt = ST_REWARD;
            moved = 1'b1;
          end else if (wrong_lick) begin
            held_outcome = OUT_INCORRECT;
            nxt = ST_PUNISH;
            moved = 1'b1;
          end else if (w.timer_expired || !w.in_position) begin
            held_outcome = OUT_NORESP;
            nxt = ST_ITI;
            moved = 1'b1;
          end
        end
        ST_REWARD, ST_PUNISH: begin
          if (w.timer_expired) begin
            nxt = ST_ITI;
            moved = 1'b1;
          end
        end
        ST_ITI: begin
          if (w.timer_expired) begin
            nxt = ST_IDLE;
            moved = 1'b1;
          end
        end
        default: ;
      endcase
    end

    r.state_now = nxt;
    if (moved) begin
      seq_state = nxt;
      r.entered = 1'b1;
      case (nxt)
        ST_SAMPLE1: begin
          r.tone_command = TONE_SAMPLE1;
          r.timer_select = TMR_TRAIN;
        end
        ST_SAMPLE2: begin
          r.tone_command = TONE_SAMPLE2;
          r.timer_select = TMR_TRAIN;
        end
        ST_DELAY:    r.timer_select = TMR_DELAY;
        ST_GOCUE: begin
          r.tone_command = TONE_GOCUE;
          r.timer_select = TMR_CUE;
        end
        ST_RESPONSE: r.timer_select = TMR_RESPONSE;
        ST_REWARD:   r.timer_select = TMR_CONSUME;
        ST_PUNISH:   r.timer_select = TMR_PUNISH;
        ST_ITI: begin
          r.timer_select  = TMR_ITI;
          r.trial_booked  = 1'b1;
          r.trial_outcome = held_outcome;
        end
        default: ;  // idle: no tone, no timer
      endcase
    end
    return r;
  endfunction

  function automatic inp_t word_of(input bit l1, input bit l2, input bit pos,
                                   input bit tmo, input bit coin);
    inp_t w;
    w.lick_spout1   = l1;
    w.lick_spout2   = l2;
    w.in_position   = pos;
    w.timer_expired = tmo;
    w.coin_bit      = coin;
    return w;
  endfunction

  // Random word biased toward whole trials from the current state;
  // one word in five is plain noise.
  function automatic inp_t shaped_word();
    inp_t w;
    w = inp_t'(5'($urandom_range(31)));
    if ($urandom_range(99) < 20) return w;
    case (seq_state)
      ST_IDLE: w.in_position = ($urandom_range(99) < 70);
      ST_SAMPLE1, ST_SAMPLE2, ST_DELAY, ST_GOCUE: begin
        w.in_position = ($urandom_range(99) < 95);
        w.lick_spout1 = ($urandom_range(99) < 8);
        w.lick_spout2 = ($urandom_range(99) < 8);
      end
      ST_RESPONSE: begin
        w.in_position   = ($urandom_range(99) < 90);
        w.lick_spout1   = ($urandom_range(99) < 30);
        w.lick_spout2   = ($urandom_range(99) < 30);
        w.timer_expired = ($urandom_range(99) < 25);
      end
      default: ;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: optional idle cycles, then offer the word and hold it until
  // taken. The expectation is computed right at the taking edge.
  // ---------------------------------------------------------------------
  task automatic send_word(input inp_t w);
    res_t want;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    lick_spout1   <= w.lick_spout1;
    lick_spout2   <= w.lick_spout2;
    in_position   <= w.in_position;
    timer_expired <= w.timer_expired;
    coin_bit      <= w.coin_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_step(w);
    expected_results.push_back(want);
    n_words++;
    if (want.trial_booked) n_booked[want.trial_outcome]++;
  endtask

  // Drop valid and wait for every outstanding result, plus pipeline slack
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write, then a back-to-back read of the same register
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);  // write lands here
    if (addr == ADDR_MAX_REPEAT) begin
      cfg_max_repeat = data[7:0];
      want = {24'd0, data[7:0]};
    end else begin
      cfg_early_punish = data[0];
      want = {31'd0, data[0]};
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata at 0x%0h: expected %0d, got %0d", addr, want, prdata);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] max_rep, input logic punish);
    wait_drained();
    write_reg(ADDR_MAX_REPEAT, {24'd0, max_rep});
    write_reg(ADDR_EARLY_PUNISH, {31'd0, punish});
  endtask

  task automatic set_idling(input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall, or a forced hold-off counted down here
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected (state_now %0d)", state_now);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("state_now",     32'(want.state_now),     32'(state_now));
        check_field("entered",       32'(want.entered),       32'(entered));
        check_field("tone_command",  32'(want.tone_command),  32'(tone_command));
        check_field("reward_spout",  32'(want.reward_spout),  32'(reward_spout));
        check_field("timer_select",  32'(want.timer_select),  32'(timer_select));
        check_field("trial_booked",  32'(want.trial_booked),  32'(trial_booked));
        check_field("trial_outcome", 32'(want.trial_outcome), 32'(trial_outcome));
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-built trials under reset settings (cap 3, early-lick punish on):
  // every state, every outcome, lick restarts, both spouts at once, and
  // leaving the port with a lick present.
  task automatic test_directed_trials();
    set_idling(0, 0);
    send_word(word_of(1, 1, 0, 1, 1));  // idle, away: stay, licks ignored
    send_word(word_of(0, 0, 1, 0, 0));  // coin 0 -> sample1
    send_word(word_of(1, 0, 1, 0, 0));  // early lick: re-enter sample1
    send_word(word_of(0, 0, 1, 1, 0));  // -> delay
    send_word(word_of(0, 1, 1, 0, 0));  // lick in delay: back to sample1
    send_word(word_of(0, 0, 1, 1, 0));  // -> delay
    send_word(word_of(0, 0, 1, 1, 0));  // -> gocue
    send_word(word_of(0, 0, 1, 0, 1));  // gocue holds
    send_word(word_of(0, 0, 1, 1, 0));  // -> response
    send_word(word_of(1, 1, 1, 0, 0));  // both spouts: scored hit, spout 1
    send_word(word_of(0, 0, 1, 1, 0));  // -> iti, booked hit
    send_word(word_of(0, 0, 1, 1, 0));  // -> idle
    send_word(word_of(0, 0, 1, 0, 1));  // coin 1 -> sample2
    send_word(word_of(0, 0, 1, 1, 1));  // -> delay
    send_word(word_of(0, 0, 1, 1, 1));  // -> gocue
    send_word(word_of(0, 0, 1, 1, 1));  // -> response
    send_word(word_of(1, 0, 1, 0, 1));  // wrong spout -> punish
    send_word(word_of(0, 0, 0, 1, 0));  // -> iti, booked incorrect
    send_word(word_of(0, 0, 0, 1, 0));  // -> idle
    send_word(word_of(0, 0, 1, 0, 1));  // -> sample2
    send_word(word_of(1, 1, 0, 1, 1));  // away beats lick: abort
    send_word(word_of(0, 0, 0, 1, 1));  // -> idle
    send_word(word_of(0, 0, 1, 0, 1));  // third type 2 in a row
    send_word(word_of(0, 0, 1, 1, 1));
    send_word(word_of(0, 0, 1, 1, 1));
    send_word(word_of(0, 0, 1, 1, 1));  // -> response
    send_word(word_of(0, 0, 0, 0, 1));  // away in response: no response
    send_word(word_of(0, 0, 0, 1, 1));  // -> idle
  endtask

  // Cap 0 alternates the types; punish off lets licks through sample/delay
  task automatic test_repeat_cap();
    set_config(8'd0, 1'b0);
    repeat (5) begin
      send_word(word_of(0, 0, 1, 0, 1));  // coin always 1
      send_word(word_of(1, 0, 1, 0, 1));  // lick ignored, stays
      send_word(word_of(0, 1, 1, 1, 1));  // -> delay despite lick
      send_word(word_of(0, 0, 0, 0, 1));  // away -> abort
      send_word(word_of(0, 0, 0, 1, 1));  // -> idle
    end
  endtask

  // Cap 255: a long run of one type walks the run length up to the top
  task automatic test_run_saturation();
    inp_t w;
    set_config(8'd255, 1'b1);
    set_idling(0, 0);
    repeat (257) begin
      w = inp_t'(5'($urandom_range(31)));
      w.in_position = 1'b1;
      w.coin_bit = 1'b1;
      send_word(w);                 // draw
      w = inp_t'(5'($urandom_range(31)));
      w.in_position = 1'b0;
      send_word(w);                 // abort
      w = inp_t'(5'($urandom_range(31)));
      w.timer_expired = 1'b1;
      send_word(w);                 // back to idle
    end
  endtask

  // Receiver holds off long enough for the block to back up into in_stall
  task automatic test_backpressure();
    set_config(8'd3, 1'b1);
    set_idling(0, 0);
    hold_left <= 40;
    repeat (30) send_word(shaped_word());
  endtask

  // Shaped random trials across idling mixes and register settings
  task automatic test_random_phases();
    int gaps[4]   = '{0, 57, 0, 13};
    int stalls[4] = '{0, 0, 57, 13};
    int caps[4]   = '{3, 0, 1, 200};
    int pun[4]    = '{1, 0, 1, 0};
    for (int p = 0; p < 4; p++) begin
      set_config(caps[p][7:0], pun[p][0]);
      set_idling(gaps[p], stalls[p]);
      repeat (300) send_word(shaped_word());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_trials();
    test_repeat_cap();
    test_run_saturation();
    test_backpressure();
    test_random_phases();
    wait_drained();
    set_idling(0, 0);
    $display("Ran %0d polling words, checked %0d result words.", n_words, n_checked);
    $display("Trials booked: %0d hit, %0d incorrect, %0d no response, %0d abort.",
             n_booked[OUT_HIT], n_booked[OUT_INCORRECT], n_booked[OUT_NORESP],
             n_booked[OUT_ABORT]);
    if (n_errors == 0) begin
      $display("tb_two_tone_discrimination_trial: PASS");
    end else begin
      $display("tb_two_tone_discrimination_trial: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_two_tone_discrimination_trial: FAIL");
    $finish;
  end

endmodule
